FILE: design/dtpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtpc_pkg
// Shared types and constants for the digit trie prefix conflict checker.
// ----------------------------------------------------------------------------
package dtpc_pkg;

	localparam int NODES      = 64;
	localparam int DIGITS     = 10;
	localparam int NODE_W     = 6;
	localparam int LINKS_W    = DIGITS * NODE_W;
	localparam int USED_W     = 7;
	localparam int DIGIT_W    = 4;

	localparam logic KIND_DIGIT = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} item_t;

	typedef struct packed {
		logic prefix_free;
		logic overflow;
	} result_t;

	typedef struct packed {
		logic               root_clr;
		logic               rd_link_en;
		logic [NODE_W-1:0]  rd_link_addr;
		logic               wr_link_en;
		logic [NODE_W-1:0]  wr_link_addr;
		logic [LINKS_W-1:0] wr_link_data;
		logic               rd_end_en;
		logic [NODE_W-1:0]  rd_end_addr;
		logic               wr_end_en;
		logic [NODE_W-1:0]  wr_end_addr;
		logic               wr_end_data;
	} tbl_req_t;

endpackage : dtpc_pkg
`default_nettype wire

FILE: design/dtpc_node_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtpc_node_table
// Node table of the trie: child links and end marks in synchronous memory,
// with the root entry reading as empty until it is written after a clear.
// ----------------------------------------------------------------------------
module dtpc_node_table (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire dtpc_pkg::tbl_req_t      req,
	output logic [dtpc_pkg::LINKS_W-1:0] link_data,
	output logic                         end_data
);
	import dtpc_pkg::*;

	localparam int DEPTH = 1 << NODE_W;

	logic [LINKS_W-1:0] links_mem [DEPTH];
	logic               ends_mem  [DEPTH];
	logic [LINKS_W-1:0] link_rd_q;
	logic               end_rd_q;
	logic               root_zero_q;
	logic               root_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_valid_q <= 1'b0;
		end else if (req.root_clr) begin
			root_valid_q <= 1'b0;
		end else if (req.wr_link_en && req.wr_link_addr == '0) begin
			root_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_link_en) begin
			links_mem[req.wr_link_addr] <= req.wr_link_data;
		end
		if (req.rd_link_en) begin
			link_rd_q   <= links_mem[req.rd_link_addr];
			root_zero_q <= (req.rd_link_addr == '0) && !root_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_end_en) begin
			ends_mem[req.wr_end_addr] <= req.wr_end_data;
		end
		if (req.rd_end_en) begin
			end_rd_q <= ends_mem[req.rd_end_addr];
		end
	end

	assign link_data = root_zero_q ? '0 : link_rd_q;
	assign end_data  = end_rd_q;

endmodule : dtpc_node_table
`default_nettype wire

FILE: design/digit_trie_prefix_conflict_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// digit_trie_prefix_conflict_check
// Inserts decimal numbers, one digit per word, into a digit trie and reports
// after each final digit whether the set since the last clear is prefix-free.
// ----------------------------------------------------------------------------
// A digit word that follows an existing node reads the child links, reads the
// end mark, checks and marks it, and posts; one that allocates a node reads
// the links, writes the parent link, writes the new node and posts. A word
// that finds the table full skips the writes, and a dropped word goes straight
// to the post step. A clear word is taken in the idle state. Each read of the
// synchronous node table returns its data in the next cycle. The block takes
// no word while one is in work; a result waits in an output register and
// stalls only the next final digit.
module digit_trie_prefix_conflict_check (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire dtpc_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output dtpc_pkg::result_t      result
);
	import dtpc_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RDL   = 3'd1;
	localparam logic [2:0] S_ALLOC = 3'd2;
	localparam logic [2:0] S_RDE   = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0]         state_q;
	logic [DIGIT_W-1:0] d_q;
	logic               fin_q;
	logic [NODE_W-1:0]  cur_q;
	logic [NODE_W-1:0]  nxt_q;
	logic [USED_W-1:0]  nodes_used_q;
	logic               conflict_q;
	logic               overflow_q;
	logic               dropped_q;
	logic               result_valid_q;
	result_t            result_q;

	tbl_req_t           req;
	logic [LINKS_W-1:0] link_data;
	logic               end_data;
	logic [NODE_W-1:0]  link_sel;
	logic [NODE_W-1:0]  new_node;
	logic               accept;
	logic               post;

	dtpc_node_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.link_data (link_data),
		.end_data  (end_data)
	);

	assign accept   = item_valid && item_ready;
	assign link_sel = link_data[NODE_W*d_q +: NODE_W];
	assign new_node = nodes_used_q[NODE_W-1:0];
	assign post     = (state_q == S_FIN) && fin_q && (!result_valid_q || result_ready);

	always_comb begin
		req = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && item.kind == KIND_CLEAR) begin
					req.root_clr = 1'b1;
				end else if (accept && !dropped_q && item.digit < DIGIT_W'(DIGITS)) begin
					req.rd_link_en   = 1'b1;
					req.rd_link_addr = cur_q;
				end
			end
			S_RDL: begin
				if (link_sel != '0) begin
					req.rd_end_en   = 1'b1;
					req.rd_end_addr = link_sel;
				end else if (nodes_used_q < USED_W'(NODES)) begin
					req.wr_link_en   = 1'b1;
					req.wr_link_addr = cur_q;
					req.wr_link_data = link_data
						| (LINKS_W'(new_node) << (NODE_W * d_q));
					req.wr_end_en    = 1'b1;
					req.wr_end_addr  = new_node;
					req.wr_end_data  = fin_q;
				end
			end
			S_ALLOC: begin
				req.wr_link_en   = 1'b1;
				req.wr_link_addr = cur_q;
				req.wr_link_data = '0;
			end
			S_RDE: begin
				if (fin_q) begin
					req.wr_end_en   = 1'b1;
					req.wr_end_addr = nxt_q;
					req.wr_end_data = 1'b1;
				end
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cur_q          <= '0;
			nodes_used_q   <= USED_W'(1);
			conflict_q     <= 1'b0;
			overflow_q     <= 1'b0;
			dropped_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (post) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.kind == KIND_CLEAR) begin
							cur_q        <= '0;
							nodes_used_q <= USED_W'(1);
							conflict_q   <= 1'b0;
							overflow_q   <= 1'b0;
							dropped_q    <= 1'b0;
						end else if (dropped_q) begin
							state_q <= S_FIN;
						end else if (item.digit >= DIGIT_W'(DIGITS)) begin
							dropped_q <= 1'b1;
							state_q   <= S_FIN;
						end else begin
							state_q <= S_RDL;
						end
					end
				end
				S_RDL: begin
					if (link_sel != '0) begin
						nxt_q   <= link_sel;
						state_q <= S_RDE;
					end else if (nodes_used_q < USED_W'(NODES)) begin
						cur_q        <= new_node;
						nodes_used_q <= nodes_used_q + USED_W'(1);
						state_q      <= S_ALLOC;
					end else begin
						overflow_q <= 1'b1;
						dropped_q  <= 1'b1;
						state_q    <= S_FIN;
					end
				end
				S_ALLOC: begin
					state_q <= S_FIN;
				end
				S_RDE: begin
					if (end_data || fin_q) begin
						conflict_q <= 1'b1;
					end
					cur_q   <= nxt_q;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!fin_q) begin
						state_q <= S_IDLE;
					end else if (post) begin
						cur_q     <= '0;
						dropped_q <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d_q   <= item.digit;
			fin_q <= item.last;
		end
		if (post) begin
			result_q.prefix_free <= !conflict_q;
			result_q.overflow    <= overflow_q;
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_used_q >= USED_W'(1) && nodes_used_q <= USED_W'(NODES))
		else $error("node count out of range");

	a_alloc_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_end_en |-> req.wr_end_addr != '0)
		else $error("end mark written at root");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == S_FIN) && $past(fin_q))
		else $error("result posted outside the final step");

	a_clear_wipes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.kind == KIND_CLEAR |=>
			nodes_used_q == USED_W'(1) && !conflict_q && !overflow_q && cur_q == '0)
		else $error("clear did not restore the set");

endmodule : digit_trie_prefix_conflict_check
`default_nettype wire

FILE: test/tb_digit_trie_prefix_conflict_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_digit_trie_prefix_conflict_check
// Streams digit words and clears into the checker from a directed table and
// then from random sets of numbers. A local digit trie predicts the verdicts
// that the table does not give. Verdicts are matched in order against the
// block's output while both ports idle at random, except in the last phase.
// ----------------------------------------------------------------------------
module tb_digit_trie_prefix_conflict_check;
	import dtpc_pkg::*;

	localparam int RANDOM_WORDS = 1730;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int SETTLE       = 24;

	typedef struct {
		item_t   w;
		int      reps;
		bit      typed;
		result_t want;
	} row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	logic [LINKS_W-1:0] trie_links [NODES];
	logic               trie_ends  [NODES];
	int                 trie_used;
	logic [NODE_W-1:0]  walk_node;
	logic               set_conflict;
	logic               set_overflow;
	logic               walk_dropped;

	result_t results_due [$];
	row_t    plan [$];
	int      faults = 0;
	int      words_sent = 0;
	int      cycle_count = 0;
	int      send_idle_pct = 14;
	int      recv_idle_pct = 64;

	digit_trie_prefix_conflict_check u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_digit_trie_prefix_conflict_check failed");
			$finish;
		end
	end

	function automatic void trie_wipe();
		for (int i = 0; i < NODES; i++) begin
			trie_links[i] = '0;
			trie_ends[i]  = 1'b0;
		end
		trie_used    = 1;
		walk_node    = '0;
		set_conflict = 1'b0;
		set_overflow = 1'b0;
		walk_dropped = 1'b0;
	endfunction

	function automatic void trie_insert(input item_t w, output bit has_res,
			output result_t res);
		logic [NODE_W-1:0] cur;
		logic [NODE_W-1:0] nxt;
		int                sel;
		has_res = 1'b0;
		res     = '0;
		if (w.kind == KIND_CLEAR) begin
			trie_wipe();
			return;
		end
		if (!walk_dropped) begin
			if (w.digit >= DIGITS) begin
				walk_dropped = 1'b1;
			end else begin
				sel = int'(w.digit) * NODE_W;
				cur = walk_node;
				nxt = trie_links[cur][sel +: NODE_W];
				if (nxt != '0) begin
					if (trie_ends[nxt] || w.last)
						set_conflict = 1'b1;
					cur = nxt;
				end else if (trie_used < NODES) begin
					cur = NODE_W'(trie_used);
					trie_links[cur] = '0;
					trie_ends[cur]  = 1'b0;
					trie_links[walk_node][sel +: NODE_W] = cur;
					trie_used++;
				end else begin
					set_overflow = 1'b1;
					walk_dropped = 1'b1;
				end
				if (!walk_dropped) begin
					walk_node = cur;
					if (w.last)
						trie_ends[cur] = 1'b1;
				end
			end
		end
		if (w.last) begin
			res.prefix_free = !set_conflict;
			res.overflow    = set_overflow;
			walk_node       = '0;
			walk_dropped    = 1'b0;
			has_res         = 1'b1;
		end
	endfunction

	function automatic void note_fault(input string msg);
		faults++;
		if (faults <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	function automatic void plan_row(input logic kind, input int digit, input logic last,
			input int reps, input bit typed, input logic pf, input logic ov);
		row_t r;
		r.w.kind  = kind;
		r.w.digit = DIGIT_W'(digit);
		r.w.last  = last;
		r.reps    = reps;
		r.typed   = typed;
		r.want.prefix_free = pf;
		r.want.overflow    = ov;
		plan.push_back(r);
	endfunction

	task automatic send_word(input item_t w, input bit typed, input result_t want);
		bit      has_res;
		result_t pred;
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid = 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		item       = w;
		item_valid = 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		trie_insert(w, has_res, pred);
		if (has_res)
			results_due.push_back(typed ? want : pred);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_number(input int len, input int span);
		item_t w;
		for (int i = 0; i < len; i++) begin
			w.kind  = KIND_DIGIT;
			if ($urandom_range(99) < 3)
				w.digit = DIGIT_W'($urandom_range(15, 10));
			else
				w.digit = DIGIT_W'($urandom_range(span - 1));
			w.last  = (i == len - 1);
			send_word(w, 1'b0, '0);
		end
	endtask

	task automatic hold_until_drained();
		item_valid = 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk)
		result_ready = ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (results_due.size() == 0) begin
				note_fault($sformatf("unexpected result pf=%b ovf=%b",
					result.prefix_free, result.overflow));
			end else begin
				want = results_due.pop_front();
				if (result.prefix_free !== want.prefix_free ||
						result.overflow !== want.overflow)
					note_fault($sformatf("result mismatch: expected pf=%b ovf=%b, got pf=%b ovf=%b",
						want.prefix_free, want.overflow,
						result.prefix_free, result.overflow));
			end
		end
	end

	initial begin
		item_t w;
		int    base;
		int    phase;
		int    nums;
		int    pick;

		trie_wipe();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		plan_row(KIND_DIGIT,  5, 1'b1,  1, 1'b1, 1'b1, 1'b0);
		plan_row(KIND_DIGIT,  5, 1'b1,  1, 1'b1, 1'b0, 1'b0);
		plan_row(KIND_CLEAR,  0, 1'b0,  1, 1'b0, 1'b0, 1'b0);
		plan_row(KIND_DIGIT,  1, 1'b0,  1, 1'b0, 1'b0, 1'b0);
		plan_row(KIND_DIGIT,  2, 1'b1,  1, 1'b1, 1'b1, 1'b0);
		plan_row(KIND_DIGIT,  1, 1'b1,  1, 1'b1, 1'b0, 1'b0);
		plan_row(KIND_CLEAR,  0, 1'b0,  1, 1'b0, 1'b0, 1'b0);
		plan_row(KIND_DIGIT,  9, 1'b0,  1, 1'b0, 1'b0, 1'b0);
		plan_row(KIND_DIGIT,  9, 1'b1,  1, 1'b1, 1'b1, 1'b0);
		plan_row(KIND_DIGIT,  9, 1'b0,  2, 1'b0, 1'b0, 1'b0);
		plan_row(KIND_DIGIT,  0, 1'b1,  1, 1'b1, 1'b0, 1'b0);
		// clear ignores its digit and last fields
		plan_row(KIND_CLEAR, 15, 1'b1,  1, 1'b0, 1'b0, 1'b0);
		plan_row(KIND_DIGIT, 15, 1'b0,  1, 1'b0, 1'b0, 1'b0);
		plan_row(KIND_DIGIT,  3, 1'b1,  1, 1'b1, 1'b1, 1'b0);
		plan_row(KIND_DIGIT, 10, 1'b1,  1, 1'b1, 1'b1, 1'b0);
		plan_row(KIND_DIGIT,  0, 1'b1,  1, 1'b1, 1'b1, 1'b0);
		plan_row(KIND_CLEAR,  0, 1'b0,  1, 1'b0, 1'b0, 1'b0);
		// fill the table with one long number, then overrun it
		plan_row(KIND_DIGIT,  7, 1'b0, 63, 1'b0, 1'b0, 1'b0);
		plan_row(KIND_DIGIT,  7, 1'b1,  1, 1'b1, 1'b1, 1'b1);
		plan_row(KIND_DIGIT,  7, 1'b1,  1, 1'b1, 1'b0, 1'b1);
		plan_row(KIND_DIGIT,  0, 1'b1,  1, 1'b1, 1'b0, 1'b1);
		plan_row(KIND_CLEAR,  0, 1'b0,  1, 1'b0, 1'b0, 1'b0);
		plan_row(KIND_DIGIT,  9, 1'b1,  1, 1'b1, 1'b1, 1'b0);

		foreach (plan[i])
			repeat (plan[i].reps)
				send_word(plan[i].w, plan[i].typed, plan[i].want);

		base  = words_sent;
		phase = 0;
		while (words_sent - base < RANDOM_WORDS) begin
			if ((words_sent - base) * 3 / RANDOM_WORDS > phase) begin
				phase++;
				hold_until_drained();
				send_idle_pct = (phase == 1) ? 64 : 0;
				recv_idle_pct = (phase == 1) ? 14 : 0;
			end
			if ($urandom_range(9) != 0) begin
				w.kind  = KIND_CLEAR;
				w.digit = DIGIT_W'($urandom_range(15));
				w.last  = 1'($urandom_range(1));
				send_word(w, 1'b0, '0);
			end
			nums = $urandom_range(12, 1);
			repeat (nums) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					w.kind  = ($urandom_range(9) == 0) ? KIND_CLEAR : KIND_DIGIT;
					w.digit = DIGIT_W'($urandom_range(15));
					w.last  = 1'($urandom_range(1));
					send_word(w, 1'b0, '0);
				end else if (pick < 14) begin
					send_number($urandom_range(70, 20), 10);
				end else begin
					send_number($urandom_range(5, 1), (pick < 55) ? 3 : 10);
				end
			end
		end

		item_valid = 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (faults == 0 && results_due.size() == 0)
			$display("tb_digit_trie_prefix_conflict_check passed");
		else
			$display("tb_digit_trie_prefix_conflict_check failed");
		$finish;
	end

endmodule

FILE: digit_trie_prefix_conflict_check.f
design/dtpc_pkg.sv
design/dtpc_node_table.sv
design/digit_trie_prefix_conflict_check.sv
test/tb_digit_trie_prefix_conflict_check.sv
